[hdl/dscs_pkg.sv]
// ----------------------------------------------------------------------------
// dscs_pkg: shared types and constants
// Item layouts, configuration struct and command codes of the disk sector
// command sequencer.
// ----------------------------------------------------------------------------
package dscs_pkg;

  localparam int TICK_CHECK_SHIFT = 8;

  localparam int KIND_W   = 2;
  localparam int OPCODE_W = 8;
  localparam int BLOCK_W  = 21;
  localparam int DMA_W    = 24;
  localparam int BYTE_W   = 8;
  localparam int TICKS_W  = 16;
  localparam int TRIES_W  = 3;
  localparam int SPINS_W  = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POLL    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_BUDGET   = 2'd2;

  // controller completion bytes and result codes
  localparam logic [BYTE_W-1:0] ST_DONE    = 8'h80;
  localparam logic [BYTE_W-1:0] ST_RETRY   = 8'h76;
  localparam logic [BYTE_W-1:0] ST_PENDING = 8'hff;
  localparam logic [BYTE_W-1:0] ST_SUCCESS = 8'h00;

  localparam logic [TICKS_W-1:0] TIMEOUT_TICKS_RST = 16'd300;
  localparam logic [TRIES_W-1:0] RETRY_LIMIT_RST   = 3'd5;
  localparam logic [SPINS_W-1:0] SPIN_BUDGET_RST   = 21'd2000000;

  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;
  // low bits of the spin count that must be clear for a tick deadline check
  localparam logic [SPINS_W-1:0] CHK_MASK =
    SPINS_W'((64'd1 << TICK_CHECK_SHIFT) - 64'd1);

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [OPCODE_W-1:0] opcode;
    logic [BLOCK_W-1:0]  block_number;
    logic [DMA_W-1:0]    dma_address;
    logic [BYTE_W-1:0]   completion_byte;
  } in_t;

  typedef struct packed {
    logic                go_level;
    logic                issue;
    logic [OPCODE_W-1:0] cmd_opcode;
    logic [BLOCK_W-1:0]  cmd_block;
    logic                cmd_sectors;
    logic [DMA_W-1:0]    cmd_dma;
    logic                done_res;
    logic [BYTE_W-1:0]   result_status;
    logic                busy_res;
  } out_t;

  typedef struct packed {
    logic [TICKS_W-1:0] timeout_ticks;
    logic [TRIES_W-1:0] retry_limit;
    logic [SPINS_W-1:0] spin_budget;
  } cfg_t;

endpackage

[hdl/disk_sector_command_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// disk_sector_command_sequencer_unit: single-sector disk command sequencer
//
//   channel  direction  handshake              payload
//   in       in         in_valid / in_ready    in_data  (dscs_pkg::in_t)
//   out      out        out_valid / out_ready  out_data (dscs_pkg::out_t)
//   cfg      in         cfg_we                 cfg_index, cfg_data
//
// One result item per input item, one item per cycle sustained while out_ready
// stays high. An item passes through the input register, then the sequencer
// logic into the result register. Sync reset clears the sequencer to idle and
// loads the default configuration. With the result register held, one more
// item is taken into the input register before in_ready drops.
// ----------------------------------------------------------------------------
module disk_sector_command_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dscs_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dscs_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [dscs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dscs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dscs_pkg::*;

  cfg_t cfg;
  in_t  in_reg;
  logic in_full;
  logic advance;
  out_t result;

  dscs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // held item moves on when the result register is free or being emptied
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_reg <= in_data;
  end

  dscs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= result;
  end

`ifndef SYNTHESIS
  a_stall_keeps_item: assert property (@(posedge clk) disable iff (rst)
    in_full && out_valid && !out_ready |=> in_full)
    else $error("held item dropped while output stalled");

  a_ready_only_when_room: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid && !out_ready)
    else $error("input stalled without cause");

  a_issue_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.issue && out_data.done_res))
    else $error("issue and done on the same item");

  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    advance && result.issue |=> u_core.phase)
    else $error("command issued without going busy");
`endif

endmodule

[hdl/dscs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dscs_cfg_regs: configuration registers
// Write-only register file holding timeout, retry limit and spin budget.
// ----------------------------------------------------------------------------
module dscs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dscs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dscs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dscs_pkg::cfg_t                   cfg
);
  import dscs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg.retry_limit   <= RETRY_LIMIT_RST;
      cfg.spin_budget   <= SPIN_BUDGET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data[TICKS_W-1:0];
        REG_RETRY_LIMIT:   cfg.retry_limit   <= cfg_data[TRIES_W-1:0];
        REG_SPIN_BUDGET:   cfg.spin_budget   <= cfg_data[SPINS_W-1:0];
        default: ;  // no register there
      endcase
    end
  end

endmodule

[hdl/dscs_core.sv]
// ----------------------------------------------------------------------------
// dscs_core: sequencer state and result logic
// Holds the request and the attempt counters, and works out the result of
// the item in the input register; state moves on when step is high.
// ----------------------------------------------------------------------------
module dscs_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  dscs_pkg::in_t  item,
  input  dscs_pkg::cfg_t cfg,
  output dscs_pkg::out_t result
);
  import dscs_pkg::*;

  logic                phase, phase_next;
  logic [OPCODE_W-1:0] held_opcode, held_opcode_next;
  logic [BLOCK_W-1:0]  held_block, held_block_next;
  logic [DMA_W-1:0]    held_dma, held_dma_next;
  logic [TRIES_W-1:0]  tries_left, tries_left_next;
  logic [SPINS_W-1:0]  spins_left, spins_left_next;
  logic [TICKS_W-1:0]  ticks_elapsed, ticks_elapsed_next;

  logic [SPINS_W-1:0]  spins_dec;
  logic [SPINS_W-1:0]  spins_start;
  logic                issue;
  logic                done;
  logic [BYTE_W-1:0]   status;

  assign spins_dec   = spins_left - SPINS_W'(1);
  assign spins_start = (cfg.spin_budget == '0) ? SPINS_W'(1) : cfg.spin_budget;

  always_comb begin
    phase_next         = phase;
    held_opcode_next   = held_opcode;
    held_block_next    = held_block;
    held_dma_next      = held_dma;
    tries_left_next    = tries_left;
    spins_left_next    = spins_left;
    ticks_elapsed_next = ticks_elapsed;
    issue              = 1'b0;
    done               = 1'b0;
    status             = ST_SUCCESS;

    if (item.kind == KIND_REQUEST && !phase) begin
      held_opcode_next   = item.opcode;
      held_block_next    = item.block_number;
      held_dma_next      = item.dma_address;
      tries_left_next    = cfg.retry_limit;
      spins_left_next    = spins_start;
      ticks_elapsed_next = '0;
      phase_next         = 1'b1;
      issue              = 1'b1;
    end else if (item.kind == KIND_TICK && phase) begin
      if (ticks_elapsed != TICKS_MAX) ticks_elapsed_next = ticks_elapsed + TICKS_W'(1);
    end else if (item.kind == KIND_POLL && phase) begin
      unique case (item.completion_byte)
        ST_PENDING: begin
          spins_left_next = spins_dec;
          // deadline is only looked at when the low spin bits roll over
          if (spins_dec == '0 ||
              ((spins_dec & CHK_MASK) == '0 && ticks_elapsed >= cfg.timeout_ticks)) begin
            done   = 1'b1;
            status = ST_PENDING;
          end
        end
        ST_DONE: begin
          done   = 1'b1;
          status = ST_SUCCESS;
        end
        ST_RETRY: begin
          if (tries_left <= TRIES_W'(1)) begin
            done   = 1'b1;
            status = ST_RETRY;
          end else begin
            tries_left_next    = tries_left - TRIES_W'(1);
            spins_left_next    = spins_start;
            ticks_elapsed_next = '0;
            issue              = 1'b1;
          end
        end
        default: begin
          done   = 1'b1;
          status = item.completion_byte;
        end
      endcase
      if (done) phase_next = 1'b0;
    end
  end

  always_comb begin
    result.go_level      = phase_next;
    result.issue         = issue;
    result.cmd_opcode    = issue ? held_opcode_next : '0;
    result.cmd_block     = issue ? held_block_next : '0;
    result.cmd_sectors   = issue;
    result.cmd_dma       = issue ? held_dma_next : '0;
    result.done_res      = done;
    result.result_status = done ? status : '0;
    result.busy_res      = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= 1'b0;
      held_opcode   <= '0;
      held_block    <= '0;
      held_dma      <= '0;
      tries_left    <= '0;
      spins_left    <= '0;
      ticks_elapsed <= '0;
    end else if (step) begin
      phase         <= phase_next;
      held_opcode   <= held_opcode_next;
      held_block    <= held_block_next;
      held_dma      <= held_dma_next;
      tries_left    <= tries_left_next;
      spins_left    <= spins_left_next;
      ticks_elapsed <= ticks_elapsed_next;
    end
  end

endmodule

[dv/disk_sector_command_sequencer_unit_tb.sv]
// ----------------------------------------------------------------------------
// disk_sector_command_sequencer_unit_tb: self-checking bench for the sequencer
// Drives request, tick and poll items through the input channel, predicts
// every result item from a behavioural copy of the sequencer and compares
// each field of each result, across register settings and idling patterns.
// ----------------------------------------------------------------------------
module disk_sector_command_sequencer_unit_tb;
  import dscs_pkg::*;

  localparam logic [KIND_W-1:0]   KIND_UNUSED   = 2'd3;
  localparam logic [OPCODE_W-1:0] OP_READ       = 8'h08;
  localparam logic [OPCODE_W-1:0] OP_WRITE      = 8'h0A;
  localparam logic [SPINS_W-1:0]  DEADLINE_MASK = SPINS_W'((1 << TICK_CHECK_SHIFT) - 1);
  localparam int                  HOLD_LEN      = 80;
  // run limit, well above what ~1600 items at worst-case idling plus the
  // drains need
  localparam int unsigned         CYCLE_LIMIT   = 50_000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TIMEOUT_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // sequencer copy used for prediction
  logic [TICKS_W-1:0]  lim_ticks     = TIMEOUT_TICKS_RST;
  logic [TRIES_W-1:0]  lim_retry     = RETRY_LIMIT_RST;
  logic [SPINS_W-1:0]  lim_spin      = SPIN_BUDGET_RST;
  logic                seq_busy      = 1'b0;
  logic [OPCODE_W-1:0] held_op       = '0;
  logic [BLOCK_W-1:0]  held_blk      = '0;
  logic [DMA_W-1:0]    held_addr     = '0;
  logic [TRIES_W-1:0]  attempts_left = '0;
  logic [SPINS_W-1:0]  polls_left    = '0;
  logic [TICKS_W-1:0]  ticks_seen    = '0;

  out_t due_results[$];

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          hold_req  = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          live_items = 0;
  int          cfg_writes = 0;
  int          n_ok = 0, n_timeout = 0, n_retry_out = 0, n_other = 0, n_reissue = 0;

  disk_sector_command_sequencer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got,
               want);
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result item with nothing expected", 0, 0);
      end else begin
        want = due_results.pop_front();
        check_field("go_level", out_data.go_level, want.go_level);
        check_field("issue", out_data.issue, want.issue);
        check_field("cmd_opcode", out_data.cmd_opcode, want.cmd_opcode);
        check_field("cmd_block", out_data.cmd_block, want.cmd_block);
        check_field("cmd_sectors", out_data.cmd_sectors, want.cmd_sectors);
        check_field("cmd_dma", out_data.cmd_dma, want.cmd_dma);
        check_field("done_res", out_data.done_res, want.done_res);
        check_field("result_status", out_data.result_status, want.result_status);
        check_field("busy_res", out_data.busy_res, want.busy_res);
      end
      results_seen++;
    end
  end

  task automatic restart_attempt();
    polls_left = (lim_spin == '0) ? SPINS_W'(1) : lim_spin;
    ticks_seen = '0;
  endtask

  // advance the sequencer copy by one accepted item and queue its result
  task automatic advance_sequencer(input in_t it);
    out_t               r;
    logic               issue_now;
    logic               done_now;
    logic [BYTE_W-1:0]  status;
    issue_now = 1'b0;
    done_now  = 1'b0;
    status    = ST_SUCCESS;
    if (it.kind == KIND_REQUEST && !seq_busy) begin
      held_op       = it.opcode;
      held_blk      = it.block_number;
      held_addr     = it.dma_address;
      attempts_left = lim_retry;
      restart_attempt();
      seq_busy  = 1'b1;
      issue_now = 1'b1;
      live_items++;
    end else if (it.kind == KIND_TICK && seq_busy) begin
      if (ticks_seen != '1) ticks_seen = ticks_seen + 1'b1;
      live_items++;
    end else if (it.kind == KIND_POLL && seq_busy) begin
      if (it.completion_byte == ST_PENDING) begin
        polls_left = polls_left - 1'b1;
        // tick deadline only looked at when the low count bits are clear
        if (polls_left == '0 ||
            ((polls_left & DEADLINE_MASK) == '0 && ticks_seen >= lim_ticks)) begin
          done_now = 1'b1;
          status   = ST_PENDING;
          n_timeout++;
        end
      end else if (it.completion_byte == ST_DONE) begin
        done_now = 1'b1;
        status   = ST_SUCCESS;
        n_ok++;
      end else if (it.completion_byte == ST_RETRY) begin
        if (attempts_left <= 1) begin
          done_now = 1'b1;
          status   = ST_RETRY;
          n_retry_out++;
        end else begin
          attempts_left = attempts_left - 1'b1;
          restart_attempt();
          issue_now = 1'b1;
          n_reissue++;
        end
      end else begin
        done_now = 1'b1;
        status   = it.completion_byte;
        n_other++;
      end
      if (done_now) seq_busy = 1'b0;
      live_items++;
    end
    r.go_level      = seq_busy;
    r.issue         = issue_now;
    r.cmd_opcode    = issue_now ? held_op : '0;
    r.cmd_block     = issue_now ? held_blk : '0;
    r.cmd_sectors   = issue_now;
    r.cmd_dma       = issue_now ? held_addr : '0;
    r.done_res      = done_now;
    r.result_status = done_now ? status : '0;
    r.busy_res      = seq_busy;
    due_results.push_back(r);
  endtask

  function automatic in_t make_item(input logic [KIND_W-1:0] k,
                                    input logic [BYTE_W-1:0] b);
    logic [63:0] raw;
    in_t         it;
    raw = {$urandom(), $urandom()};
    it  = raw[$bits(in_t)-1:0];
    it.kind = k;
    it.completion_byte = b;
    return it;
  endfunction

  // valid is left high after acceptance; an idle gap in the next send or a drain lowers it
  task automatic send_item(input in_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    advance_sequencer(it);
    items_sent++;
  endtask

  task automatic send_kind(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
    send_item(make_item(k, b));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int send_idle, input int recv_stall);
    idle_pct = send_idle;
    stall_pct <= recv_stall;
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] t,
                              input logic [CFG_DATA_W-1:0] r,
                              input logic [CFG_DATA_W-1:0] s);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data  <= t;
    @(posedge clk);
    lim_ticks = t[TICKS_W-1:0];
    cfg_index <= REG_RETRY_LIMIT;
    cfg_data  <= r;
    @(posedge clk);
    lim_retry = r[TRIES_W-1:0];
    cfg_index <= REG_SPIN_BUDGET;
    cfg_data  <= s;
    @(posedge clk);
    lim_spin = s[SPINS_W-1:0];
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic test_directed();
    in_t req;
    set_idling(0, 0);
    // ticks, polls and the unused kind are ignored while idle
    send_kind(KIND_TICK, ST_DONE);
    send_kind(KIND_POLL, ST_DONE);
    send_kind(KIND_UNUSED, ST_DONE);
    req = make_item(KIND_REQUEST, ST_PENDING);
    req.opcode = OP_READ;
    req.block_number = '1;
    req.dma_address = '1;
    send_item(req);
    req.opcode = '1;
    req.block_number = '0;
    send_item(req);                        // busy: ignored
    send_kind(KIND_UNUSED, ST_PENDING);
    send_kind(KIND_TICK, ST_PENDING);
    send_kind(KIND_POLL, ST_PENDING);
    send_kind(KIND_POLL, ST_DONE);
    req = make_item(KIND_REQUEST, ST_DONE);
    req.opcode = OP_WRITE;
    req.block_number = '0;
    req.dma_address = '0;
    send_item(req);
    repeat (5) send_kind(KIND_POLL, ST_RETRY);   // retry budget used up
    req.opcode = '0;
    send_item(req);
    send_kind(KIND_POLL, 8'h00);           // plain controller byte
    send_kind(KIND_REQUEST, ST_DONE);
    send_kind(KIND_POLL, 8'hfe);
  endtask

  task automatic test_register_extremes();
    set_idling(32, 32);
    // zero budget acts as one poll, zero retry limit as one attempt
    write_config(21'd0, 21'd0, 21'd0);
    send_kind(KIND_REQUEST, ST_DONE);
    send_kind(KIND_POLL, ST_PENDING);
    send_kind(KIND_REQUEST, ST_DONE);
    send_kind(KIND_POLL, ST_RETRY);
    // zero timeout: deadline passed at the first check
    write_config(21'd0, 21'd7, 21'd257);
    send_kind(KIND_REQUEST, ST_DONE);
    send_kind(KIND_POLL, ST_PENDING);
    // reissue clears the tick count
    write_config(21'd1, 21'd3, 21'd257);
    send_kind(KIND_REQUEST, ST_DONE);
    send_kind(KIND_TICK, ST_DONE);
    send_kind(KIND_POLL, ST_RETRY);
    send_kind(KIND_POLL, ST_PENDING);
    send_kind(KIND_TICK, ST_DONE);
    send_kind(KIND_POLL, ST_RETRY);
    send_kind(KIND_POLL, ST_RETRY);
    send_kind(KIND_REQUEST, ST_DONE);
    send_kind(KIND_TICK, ST_DONE);
    send_kind(KIND_POLL, ST_PENDING);
    write_config(21'(TICKS_MAX), 21'd7, '1);
    send_kind(KIND_REQUEST, ST_DONE);
    send_kind(KIND_POLL, ST_PENDING);
    send_kind(KIND_POLL, ST_DONE);
    // upper data bits beyond the register width are dropped
    write_config(21'h1f0002, 21'h1ffff9, 21'd2);
    send_kind(KIND_REQUEST, ST_DONE);
    send_kind(KIND_POLL, ST_PENDING);
    send_kind(KIND_POLL, ST_PENDING);
    send_kind(KIND_REQUEST, ST_DONE);
    send_kind(KIND_POLL, ST_RETRY);
    write_config(21'(TIMEOUT_TICKS_RST), 21'(RETRY_LIMIT_RST), 21'(SPIN_BUDGET_RST));
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    write_config(21'd50, 21'd4, 21'd1000);
    hold_req <= hold_req + 1;
    send_kind(KIND_REQUEST, ST_DONE);
    repeat (30) send_kind($urandom_range(1) ? KIND_TICK : KIND_POLL, ST_PENDING);
    // sender stops mid-request until everything is back
    wait_drain();
    send_kind(KIND_POLL, ST_RETRY);
    send_kind(KIND_POLL, ST_DONE);
  endtask

  task automatic run_sequence();
    in_t req;
    int  n;
    int  pick;
    n = ($urandom_range(15) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 16);
    req = make_item(KIND_REQUEST, BYTE_W'($urandom));
    if ($urandom_range(7) == 0) req.opcode = $urandom_range(1) ? OP_READ : OP_WRITE;
    send_item(req);
    while (n > 0 && seq_busy) begin
      pick = $urandom_range(99);
      if (pick < 35)      send_kind(KIND_TICK, BYTE_W'($urandom));
      else if (pick < 85) send_kind(KIND_POLL, ST_PENDING);
      else if (pick < 90) send_kind(KIND_POLL, ST_RETRY);
      else if (pick < 94) send_kind(KIND_REQUEST, BYTE_W'($urandom));
      else if (pick < 97) send_kind(KIND_UNUSED, BYTE_W'($urandom));
      else                send_kind(KIND_POLL, BYTE_W'($urandom));
      n--;
    end
    while (seq_busy) begin
      pick = $urandom_range(3);
      if (pick < 2)       send_kind(KIND_POLL, ST_DONE);
      else if (pick == 2) send_kind(KIND_POLL, ST_RETRY);
      else                send_kind(KIND_POLL, BYTE_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int chunk;
    int goal;
    for (chunk = 0; chunk < 12; chunk++) begin
      case (chunk % 5)
        0: write_config(21'(TICKS_MAX), 21'd7, '1);
        1: write_config(21'd1, 21'd1, 21'd1);
        2: write_config(CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom_range(0, 7)),
                        CFG_DATA_W'($urandom_range(1, 700)));
        3: write_config(CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(1, 7)),
                        CFG_DATA_W'($urandom_range(256, 520)));
        default: write_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                              CFG_DATA_W'($urandom));
      endcase
      case (chunk % 4)
        0: set_idling(0, 0);
        1: set_idling(58, 0);
        2: set_idling(0, 58);
        default: set_idling(32, 32);
      endcase
      goal = live_items + 115;
      while (live_items < goal) begin
        if ($urandom_range(3) == 0)
          send_kind(KIND_W'($urandom_range(1, 3)), BYTE_W'($urandom));
        run_sequence();
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drain();
    repeat (6) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch("expected results never arrived", 0, due_results.size());
    $display("Sent %0d items (%0d acted on), checked %0d results over %0d register settings.",
             items_sent, live_items, results_seen, cfg_writes);
    $display("Outcomes: %0d success, %0d timeout, %0d retry exhausted, %0d other, %0d reissues.",
             n_ok, n_timeout, n_retry_out, n_other, n_reissue);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
